// ===== hdl/rsi_pkg.sv =====
// shared constants for the ray sphere intersection block
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int COORD_W = 32;
  localparam int DIR_W   = 18;
  localparam int RAD_W   = 31;
  localparam int DIST_W  = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_index_t;

endpackage

// ===== hdl/ray_sphere_intersect.sv =====
// ray sphere intersection, fully pipelined
// the square root uses one stage per root bit
// throughput: one ray per cycle, the whole pipeline holds while the result beat waits
// rst (synchronous) clears all valid bits and sets the center to 0 and the radius to 1.0
`timescale 1ns / 1ps
module ray_sphere_intersect
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 2 zero bits
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // hit, distance
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int OPW = COORD_W + 1;
  localparam int PDW = OPW + DIR_W;
  localparam int B2W = PDW + 2;
  localparam int BW  = B2W - FRAC_BITS;
  localparam int BL  = BW / 2;
  localparam int BH  = BW - BL;
  localparam int SQW = 2 * OPW;
  localparam int OSW = SQW + 2;
  localparam int CW  = (2 * BW + 1 > OSW) ? 2 * BW + 1 : OSW;
  localparam int SW  = CW + (CW % 2);
  localparam int RW  = SW / 2;
  localparam int RMW = RW + 2;
  localparam int TW  = ((BW > RW + 1) ? BW : RW + 1) + 2;
  localparam longint EPS = ((64'sd1 <<< FRAC_BITS) + 64'sd5000) / 64'sd10000;

  logic signed [COORD_W-1:0] cx, cy, cz;
  logic [RAD_W-1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0;
      cy <= '0;
      cz <= '0;
      radius <= RAD_W'(65536);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CENTER_X: cx <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y: cy <= cfg_data[COORD_W-1:0];
        REG_CENTER_Z: cz <= cfg_data[COORD_W-1:0];
        REG_RADIUS:   radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [COORD_W-1:0] ox, oy, oz;
  logic signed [DIR_W-1:0] dx_in, dy_in, dz_in;
  assign ox = s_tdata[COORD_W-1:0];
  assign oy = s_tdata[2*COORD_W-1:COORD_W];
  assign oz = s_tdata[3*COORD_W-1:2*COORD_W];
  assign dx_in = s_tdata[3*COORD_W+DIR_W-1:3*COORD_W];
  assign dy_in = s_tdata[3*COORD_W+2*DIR_W-1:3*COORD_W+DIR_W];
  assign dz_in = s_tdata[3*COORD_W+3*DIR_W-1:3*COORD_W+2*DIR_W];

  // stage 1: offset from origin to center
  logic v1;
  logic signed [OPW-1:0] opx1, opy1, opz1;
  logic signed [DIR_W-1:0] dx1, dy1, dz1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      opx1 <= OPW'(cx) - OPW'(ox);
      opy1 <= OPW'(cy) - OPW'(oy);
      opz1 <= OPW'(cz) - OPW'(oz);
      dx1 <= dx_in;
      dy1 <= dy_in;
      dz1 <= dz_in;
    end
  end

  // stage 2: products
  logic v2;
  logic signed [PDW-1:0] pdx2, pdy2, pdz2;
  logic [SQW-1:0] sqx2, sqy2, sqz2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pdx2 <= PDW'(opx1 * dx1);
      pdy2 <= PDW'(opy1 * dy1);
      pdz2 <= PDW'(opz1 * dz1);
      sqx2 <= SQW'(opx1 * opx1);
      sqy2 <= SQW'(opy1 * opy1);
      sqz2 <= SQW'(opz1 * opz1);
    end
  end

  // stage 3: dot product and squared length
  logic v3;
  logic signed [B2W-1:0] b2_sum;
  logic signed [BW-1:0] b_floor;
  logic signed [BW-1:0] b3;
  logic [BW-1:0] bmag3;
  logic [OSW-1:0] opsq3;
  assign b2_sum = B2W'(pdx2) + B2W'(pdy2) + B2W'(pdz2);
  assign b_floor = BW'(b2_sum >>> FRAC_BITS);
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b3 <= b_floor;
      bmag3 <= b_floor[BW-1] ? BW'(-b_floor) : BW'(b_floor);
      opsq3 <= OSW'(sqx2) + OSW'(sqy2) + OSW'(sqz2);
    end
  end

  // stage 4: split square of b, radius squared
  logic v4;
  logic signed [BW-1:0] b4;
  logic [OSW-1:0] opsq4;
  logic [2*BH-1:0] phh4;
  logic [BH+BL-1:0] phl4;
  logic [2*BL-1:0] pll4;
  logic [2*RAD_W-1:0] rr4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b4 <= b3;
      opsq4 <= opsq3;
      phh4 <= bmag3[BW-1:BL] * bmag3[BW-1:BL];
      phl4 <= bmag3[BW-1:BL] * bmag3[BL-1:0];
      pll4 <= bmag3[BL-1:0] * bmag3[BL-1:0];
      rr4 <= radius * radius;
    end
  end

  // stage 5: discriminant
  logic [CW-1:0] pos;
  assign pos = (CW'(phh4) << (2 * BL)) + (CW'(phl4) << (BL + 1)) + CW'(pll4) + CW'(rr4);

  logic vld [0:RW];
  logic neg [0:RW];
  logic signed [BW-1:0] bq [0:RW];
  logic [SW-1:0] detq [0:RW];
  logic [RMW-1:0] remq [0:RW];
  logic [RW-1:0] rootq [0:RW];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bq[0] <= b4;
      neg[0] <= pos < CW'(opsq4);
      detq[0] <= SW'(pos - CW'(opsq4));
      remq[0] <= '0;
      rootq[0] <= '0;
    end
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    assign rem_sh = {remq[k][RMW-3:0], detq[k][SW-1:SW-2]};
    assign trial = {rootq[k], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        bq[k+1] <= bq[k];
        neg[k+1] <= neg[k];
        detq[k+1] <= detq[k] << 2;
        if (rem_sh >= trial) begin
          remq[k+1] <= rem_sh - trial;
          rootq[k+1] <= {rootq[k][RW-2:0], 1'b1};
        end else begin
          remq[k+1] <= rem_sh;
          rootq[k+1] <= {rootq[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  // root selection and saturation
  logic signed [TW-1:0] tb, ts, t1, t2, tsel;
  logic hit_c;
  assign tb = TW'(bq[RW]);
  assign ts = $signed(TW'(rootq[RW]));
  assign t1 = tb - ts;
  assign t2 = tb + ts;
  always_comb begin
    hit_c = 1'b0;
    tsel = '0;
    if (!neg[RW]) begin
      if (t1 > TW'(EPS)) begin
        hit_c = 1'b1;
        tsel = t1;
      end else if (t2 > TW'(EPS)) begin
        hit_c = 1'b1;
        tsel = t2;
      end
    end
  end

  logic hit;
  logic [DIST_W-1:0] distance;
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vld[RW];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_c;
      if (tsel > $signed({{(TW-DIST_W){1'b0}}, {DIST_W{1'b1}}}))
        distance <= '1;
      else
        distance <= tsel[DIST_W-1:0];
    end
  end
  assign m_tdata = {distance, hit};

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_DATA_W-1:1] == '0))
    else $error("miss beat with nonzero distance");

  a_hit_eps: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[OUT_DATA_W-1:1] > DIST_W'(EPS)))
    else $error("hit distance not beyond eps");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result beat right after reset");

endmodule
